// ----- hdl/earm_pkg.sv -----
// Shared types, constants and arithmetic helpers of the rotation matrix pipeline.
package earm_pkg;

    localparam int CORDIC_ITERATIONS = 28;
    localparam int ATAN_ENTRIES      = 63;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < ATAN_ENTRIES) ?
                                       CORDIC_ITERATIONS : ATAN_ENTRIES;
    localparam int NUM_ANGLES        = 3;

    localparam logic signed [63:0] GAIN_Q60  = 64'sd700114967507363239;
    localparam logic signed [63:0] HALF_Q30  = 64'sd536870912;
    localparam logic signed [63:0] MAX_S32   = 64'sd2147483647;
    localparam logic signed [63:0] MIN_S32   = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] angle_omega;
        logic signed [31:0] angle_phi;
        logic signed [31:0] angle_kappa;
    } angles_t;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
    } matrix_t;

    // Elaboration-time long division (shift and subtract).
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] atan_inv_odd_q62(input logic [63:0] n);
        logic [63:0] p;
        logic [63:0] n2;
        logic [63:0] sum;
        logic [63:0] t;
        p   = udiv64(64'd1 << 62, n);
        n2  = n * n;
        sum = '0;
        for (int k = 0; k < 64; k++) begin
            if (p != 64'd0) begin
                t   = udiv64(p, 64'(2 * k + 1));
                sum = (k % 2 == 1) ? sum - t : sum + t;
                p   = udiv64(p, n2);
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] atan_pow2_q62(input int i);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] t;
        p   = (64'd1 << 62) >> i;
        sum = '0;
        for (int k = 0; k < 64; k++) begin
            if (p != 64'd0) begin
                t   = udiv64(p, 64'(2 * k + 1));
                sum = (k % 2 == 1) ? sum - t : sum + t;
                p   = (2 * i < 64) ? (p >> (2 * i)) : 64'd0;
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] quarter_pi_q62();
        return 64'd4 * atan_inv_odd_q62(64'd5) - atan_inv_odd_q62(64'd239);
    endfunction

    function automatic logic signed [63:0] atan_q58(input int i);
        logic [63:0] v;
        v = (i == 0) ? quarter_pi_q62() : atan_pow2_q62(i);
        return $signed((v + 64'd8) >> 4);
    endfunction

    localparam logic signed [63:0] PI_Q58      = $signed((64'd4 * quarter_pi_q62() + 64'd8) >> 4);
    localparam logic signed [63:0] TWO_PI_Q58  = PI_Q58 + PI_Q58;
    localparam logic signed [63:0] HALF_PI_Q58 = PI_Q58 / 2;

    function automatic logic signed [63:0] round30(input logic signed [63:0] v);
        return (v + HALF_Q30) >>> 30;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > MAX_S32)
            r = MAX_S32;
        else if (v < MIN_S32)
            r = MIN_S32;
        return r[31:0];
    endfunction

endpackage

// ----- hdl/euler_angle_rotation_matrix.sv -----
// Pipelined omega-phi-kappa rotation matrix: angle reduction, CORDIC, products and sums.
//
//  channel  | valid         | stall         | word
//  ---------+---------------+---------------+-------------------------------
//  angles   | angle_valid   | angle_stall   | angles_t, three Q4.28 angles
//  matrix   | matrix_valid  | matrix_stall  | matrix_t, nine Q2.30 elements
//
//  One word per cycle while matrix_stall is low; stages in order: reduce, fold,
//  one CORDIC step per stage, round, two multiplier stages with the shared
//  terms rounded between them, sum and saturate.
//  Reset clears every stage valid bit at once; no clearing pass.
//  Each stage holds only while it is full and the stage after it holds, so
//  bubbles close up under a stall and the input stalls only when all are full.
module euler_angle_rotation_matrix
    import earm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    angle_valid,
    output logic    angle_stall,
    input  angles_t angles,
    output logic    matrix_valid,
    input  logic    matrix_stall,
    output matrix_t matrix
);

    localparam int S_RED  = 0;
    localparam int S_FOLD = 1;
    localparam int S_CORD = 2;
    localparam int S_RND  = S_CORD + CORDIC_STEPS;
    localparam int S_P1   = S_RND + 1;
    localparam int S_P2   = S_P1 + 1;
    localparam int S_P3   = S_P2 + 1;
    localparam int S_P4   = S_P3 + 1;
    localparam int NS     = S_P4 + 1;

    logic [NS-1:0] valid_reg;
    logic [NS:0]   rdy;

    always_comb
    begin
        rdy[NS] = !matrix_stall;
        for (int k = NS - 1; k >= 0; k--)
            rdy[k] = !valid_reg[k] || rdy[k+1];
    end

    assign angle_stall  = !rdy[0];
    assign matrix_valid = valid_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (rdy[0])
                valid_reg[0] <= angle_valid;
            for (int k = 1; k < NS; k++)
                if (rdy[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    // Reduce to [-pi, pi]
    logic signed [31:0] ang [NUM_ANGLES];
    logic signed [63:0] red_z_next [NUM_ANGLES];
    logic signed [63:0] red_z_reg  [NUM_ANGLES];

    assign ang[0] = angles.angle_omega;
    assign ang[1] = angles.angle_phi;
    assign ang[2] = angles.angle_kappa;

    always_comb
    begin
        for (int j = 0; j < NUM_ANGLES; j++)
        begin
            red_z_next[j] = {{2{ang[j][31]}}, ang[j], 30'd0};
            if (red_z_next[j] > PI_Q58)
                red_z_next[j] = red_z_next[j] - TWO_PI_Q58;
            else if (red_z_next[j] < -PI_Q58)
                red_z_next[j] = red_z_next[j] + TWO_PI_Q58;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[S_RED])
            red_z_reg <= red_z_next;
    end

    // Fold to [-pi/2, pi/2], then CORDIC
    logic signed [63:0] cx_reg  [CORDIC_STEPS+1][NUM_ANGLES];
    logic signed [63:0] cy_reg  [CORDIC_STEPS+1][NUM_ANGLES];
    logic signed [63:0] cz_reg  [CORDIC_STEPS+1][NUM_ANGLES];
    logic               neg_reg [CORDIC_STEPS+1][NUM_ANGLES];

    always_ff @(posedge clk)
    begin
        if (rdy[S_FOLD])
        begin
            for (int j = 0; j < NUM_ANGLES; j++)
            begin
                cx_reg[0][j] <= GAIN_Q60;
                cy_reg[0][j] <= '0;
                if (red_z_reg[j] > HALF_PI_Q58)
                begin
                    cz_reg[0][j]  <= red_z_reg[j] - PI_Q58;
                    neg_reg[0][j] <= 1'b1;
                end
                else if (red_z_reg[j] < -HALF_PI_Q58)
                begin
                    cz_reg[0][j]  <= red_z_reg[j] + PI_Q58;
                    neg_reg[0][j] <= 1'b1;
                end
                else
                begin
                    cz_reg[0][j]  <= red_z_reg[j];
                    neg_reg[0][j] <= 1'b0;
                end
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cord
        localparam logic signed [63:0] ATAN_I = atan_q58(i);
        always_ff @(posedge clk)
        begin
            if (rdy[S_CORD+i])
            begin
                for (int j = 0; j < NUM_ANGLES; j++)
                begin
                    neg_reg[i+1][j] <= neg_reg[i][j];
                    if (cz_reg[i][j] >= 0)
                    begin
                        cx_reg[i+1][j] <= cx_reg[i][j] - (cy_reg[i][j] >>> i);
                        cy_reg[i+1][j] <= cy_reg[i][j] + (cx_reg[i][j] >>> i);
                        cz_reg[i+1][j] <= cz_reg[i][j] - ATAN_I;
                    end
                    else
                    begin
                        cx_reg[i+1][j] <= cx_reg[i][j] + (cy_reg[i][j] >>> i);
                        cy_reg[i+1][j] <= cy_reg[i][j] - (cx_reg[i][j] >>> i);
                        cz_reg[i+1][j] <= cz_reg[i][j] + ATAN_I;
                    end
                end
            end
        end
    end

    // Undo fold, round to Q30
    logic signed [63:0] sin_w [NUM_ANGLES];
    logic signed [63:0] cos_w [NUM_ANGLES];
    logic signed [31:0] sin_reg [NUM_ANGLES];
    logic signed [31:0] cos_reg [NUM_ANGLES];

    always_comb
    begin
        for (int j = 0; j < NUM_ANGLES; j++)
        begin
            sin_w[j] = round30(neg_reg[CORDIC_STEPS][j] ? -cy_reg[CORDIC_STEPS][j]
                                                        :  cy_reg[CORDIC_STEPS][j]);
            cos_w[j] = round30(neg_reg[CORDIC_STEPS][j] ? -cx_reg[CORDIC_STEPS][j]
                                                        :  cx_reg[CORDIC_STEPS][j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[S_RND])
        begin
            for (int j = 0; j < NUM_ANGLES; j++)
            begin
                sin_reg[j] <= sin_w[j][31:0];
                cos_reg[j] <= cos_w[j][31:0];
            end
        end
    end

    // Two-factor products
    logic signed [63:0] so_sp_reg, co_sp_reg, cp_ck_reg, cp_sk_reg, co_sk_reg;
    logic signed [63:0] co_ck_reg, so_sk_reg, so_ck_reg, so_cp_reg, co_cp_reg;
    logic signed [31:0] p1_sp_reg, p1_sk_reg, p1_ck_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[S_P1])
        begin
            so_sp_reg <= sin_reg[0] * sin_reg[1];
            co_sp_reg <= cos_reg[0] * sin_reg[1];
            cp_ck_reg <= cos_reg[1] * cos_reg[2];
            cp_sk_reg <= cos_reg[1] * sin_reg[2];
            co_sk_reg <= cos_reg[0] * sin_reg[2];
            co_ck_reg <= cos_reg[0] * cos_reg[2];
            so_sk_reg <= sin_reg[0] * sin_reg[2];
            so_ck_reg <= sin_reg[0] * cos_reg[2];
            so_cp_reg <= sin_reg[0] * cos_reg[1];
            co_cp_reg <= cos_reg[0] * cos_reg[1];
            p1_sp_reg <= sin_reg[1];
            p1_sk_reg <= sin_reg[2];
            p1_ck_reg <= cos_reg[2];
        end
    end

    // Round the shared two-factor terms of the three-factor products
    logic signed [63:0] t1_w, t2_w;
    logic signed [31:0] t1_reg, t2_reg;
    logic signed [63:0] p2_cp_ck_reg, p2_cp_sk_reg, p2_co_sk_reg, p2_co_ck_reg;
    logic signed [63:0] p2_so_sk_reg, p2_so_ck_reg, p2_so_cp_reg, p2_co_cp_reg;
    logic signed [31:0] p2_sp_reg, p2_sk_reg, p2_ck_reg;

    assign t1_w = round30(so_sp_reg);
    assign t2_w = round30(co_sp_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[S_P2])
        begin
            t1_reg       <= t1_w[31:0];
            t2_reg       <= t2_w[31:0];
            p2_cp_ck_reg <= cp_ck_reg;
            p2_cp_sk_reg <= cp_sk_reg;
            p2_co_sk_reg <= co_sk_reg;
            p2_co_ck_reg <= co_ck_reg;
            p2_so_sk_reg <= so_sk_reg;
            p2_so_ck_reg <= so_ck_reg;
            p2_so_cp_reg <= so_cp_reg;
            p2_co_cp_reg <= co_cp_reg;
            p2_sp_reg    <= p1_sp_reg;
            p2_sk_reg    <= p1_sk_reg;
            p2_ck_reg    <= p1_ck_reg;
        end
    end

    // Three-factor products
    logic signed [63:0] t1_ck_reg, t1_sk_reg, t2_ck_reg, t2_sk_reg;
    logic signed [63:0] p3_cp_ck_reg, p3_cp_sk_reg, p3_co_sk_reg, p3_co_ck_reg;
    logic signed [63:0] p3_so_sk_reg, p3_so_ck_reg, p3_so_cp_reg, p3_co_cp_reg;
    logic signed [31:0] p3_sp_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[S_P3])
        begin
            t1_ck_reg    <= t1_reg * p2_ck_reg;
            t1_sk_reg    <= t1_reg * p2_sk_reg;
            t2_ck_reg    <= t2_reg * p2_ck_reg;
            t2_sk_reg    <= t2_reg * p2_sk_reg;
            p3_cp_ck_reg <= p2_cp_ck_reg;
            p3_cp_sk_reg <= p2_cp_sk_reg;
            p3_co_sk_reg <= p2_co_sk_reg;
            p3_co_ck_reg <= p2_co_ck_reg;
            p3_so_sk_reg <= p2_so_sk_reg;
            p3_so_ck_reg <= p2_so_ck_reg;
            p3_so_cp_reg <= p2_so_cp_reg;
            p3_co_cp_reg <= p2_co_cp_reg;
            p3_sp_reg    <= p2_sp_reg;
        end
    end

    // Sum, round, saturate
    matrix_t matrix_next;
    matrix_t matrix_reg;

    always_comb
    begin
        matrix_next.m00 = sat32(round30(p3_cp_ck_reg));
        matrix_next.m01 = sat32(round30(-p3_cp_sk_reg));
        matrix_next.m02 = p3_sp_reg;
        matrix_next.m10 = sat32(round30(p3_co_sk_reg + t1_ck_reg));
        matrix_next.m11 = sat32(round30(p3_co_ck_reg - t1_sk_reg));
        matrix_next.m12 = sat32(round30(-p3_so_cp_reg));
        matrix_next.m20 = sat32(round30(p3_so_sk_reg - t2_ck_reg));
        matrix_next.m21 = sat32(round30(p3_so_ck_reg + t2_sk_reg));
        matrix_next.m22 = sat32(round30(p3_co_cp_reg));
    end

    always_ff @(posedge clk)
    begin
        if (rdy[S_P4])
            matrix_reg <= matrix_next;
    end

    assign matrix = matrix_reg;

endmodule

// ----- hdl/earm_checker.sv -----
// Port-level checks of the rotation matrix pipeline, bound to the top level.
module earm_checker
    import earm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    angle_valid,
    input logic    angle_stall,
    input angles_t angles,
    input logic    matrix_valid,
    input logic    matrix_stall,
    input matrix_t matrix
);

    localparam logic signed [31:0] UNIT_BOUND = 32'sd1074790400;

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !matrix_valid)
        else $error("result word shown during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        matrix_valid && matrix_stall |=> matrix_valid && $stable(matrix))
        else $error("stalled result word changed or vanished");

    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        angle_stall |-> matrix_valid && matrix_stall)
        else $error("input held while result side free");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        matrix_valid |-> matrix.m00 <= UNIT_BOUND && matrix.m00 >= -UNIT_BOUND
                      && matrix.m11 <= UNIT_BOUND && matrix.m11 >= -UNIT_BOUND
                      && matrix.m22 <= UNIT_BOUND && matrix.m22 >= -UNIT_BOUND)
        else $error("diagonal element beyond unit range");

endmodule

bind euler_angle_rotation_matrix earm_checker u_earm_checker (.*);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the omega-phi-kappa rotation matrix pipeline.
`timescale 1ns / 100ps

module tb_top;
    import earm_pkg::*;

    localparam int LATENCY   = CORDIC_ITERATIONS + 7;
    localparam int LONG_HOLD = 4 * LATENCY;

    logic    clk;
    logic    rst_n;
    logic    angle_valid;
    logic    angle_stall;
    angles_t angles;
    logic    matrix_valid;
    logic    matrix_stall;
    matrix_t matrix;

    euler_angle_rotation_matrix dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .angle_valid  (angle_valid),
        .angle_stall  (angle_stall),
        .angles       (angles),
        .matrix_valid (matrix_valid),
        .matrix_stall (matrix_stall),
        .matrix       (matrix)
    );

    longint  atan_tab [ATAN_ENTRIES];
    longint  pi_fix;
    matrix_t pending_matrices [$];
    int      mismatches;
    int      words_sent;
    int      words_checked;
    bit      idling_on;
    int      hold_cycles;
    bit      failed;

    function automatic logic [63:0] series_inv_odd(logic [63:0] n);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] k;
        p   = (64'd1 << 62) / n;
        sum = '0;
        k   = '0;
        while (p != 0)
        begin
            if (k[0])
                sum = sum - p / (2 * k + 1);
            else
                sum = sum + p / (2 * k + 1);
            p = p / (n * n);
            k++;
        end
        return sum;
    endfunction

    function automatic logic [63:0] series_pow2(int i);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] k;
        p   = (64'd1 << 62) >> i;
        sum = '0;
        k   = '0;
        while (p != 0)
        begin
            if (k[0])
                sum = sum - p / (2 * k + 1);
            else
                sum = sum + p / (2 * k + 1);
            p = (2 * i < 64) ? (p >> (2 * i)) : 64'd0;
            k++;
        end
        return sum;
    endfunction

    function automatic longint half_up30(longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        longint r;
        r = v;
        if (v > 64'sd2147483647)
            r = 64'sd2147483647;
        else if (v < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    task automatic angle_sin_cos(input logic signed [31:0] ang, output longint s,
                                 output longint c);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z    = longint'(ang) * 64'sd1073741824;
        x    = GAIN_Q60;
        y    = 0;
        flip = 0;
        while (z > pi_fix)
            z -= 2 * pi_fix;
        while (z < -pi_fix)
            z += 2 * pi_fix;
        if (z > pi_fix / 2)
        begin
            z -= pi_fix;
            flip = 1;
        end
        else if (z < -(pi_fix / 2))
        begin
            z += pi_fix;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_ITERATIONS && i < ATAN_ENTRIES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_tab[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_tab[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = half_up30(y);
        c = half_up30(x);
    endtask

    task automatic predict_matrix(input angles_t a, output matrix_t m);
        longint so, co, sp, cp, sk, ck, t1, t2;
        angle_sin_cos(a.angle_omega, so, co);
        angle_sin_cos(a.angle_phi, sp, cp);
        angle_sin_cos(a.angle_kappa, sk, ck);
        t1    = half_up30(so * sp);
        t2    = half_up30(co * sp);
        m.m00 = clamp32(half_up30(cp * ck));
        m.m01 = clamp32(half_up30(-(cp * sk)));
        m.m02 = clamp32(sp);
        m.m10 = clamp32(half_up30(co * sk + t1 * ck));
        m.m11 = clamp32(half_up30(co * ck - t1 * sk));
        m.m12 = clamp32(half_up30(-(so * cp)));
        m.m20 = clamp32(half_up30(so * sk - t2 * ck));
        m.m21 = clamp32(half_up30(so * ck + t2 * sk));
        m.m22 = clamp32(half_up30(co * cp));
    endtask

    initial
    begin
        logic [63:0] quarter;
        quarter = 64'd4 * series_inv_odd(64'd5) - series_inv_odd(64'd239);
        pi_fix  = longint'((64'd4 * quarter + 64'd8) >> 4);
        atan_tab[0] = longint'((quarter + 64'd8) >> 4);
        for (int i = 1; i < ATAN_ENTRIES; i++)
            atan_tab[i] = longint'((series_pow2(i) + 64'd8) >> 4);
    end

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver stall: a long hold while hold_cycles is set, else random bursts while idling_on.
    initial
    begin
        int burst;
        burst = 0;
        matrix_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                matrix_stall <= 1'b1;
                hold_cycles--;
            end
            else if (burst > 0)
            begin
                matrix_stall <= 1'b1;
                burst--;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                matrix_stall <= 1'b1;
                burst = $urandom_range(0, 7);
            end
            else
                matrix_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        matrix_t want;
        if (rst_n && matrix_valid && !matrix_stall)
        begin
            if (pending_matrices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected matrix word %h", matrix);
            end
            else
            begin
                want = pending_matrices.pop_front();
                words_checked++;
                if (want != matrix)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch on word %0d", words_checked);
                        $display("  exp %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                                 want.m00, want.m01, want.m02, want.m10, want.m11,
                                 want.m12, want.m20, want.m21, want.m22);
                        $display("  got %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                                 matrix.m00, matrix.m01, matrix.m02, matrix.m10,
                                 matrix.m11, matrix.m12, matrix.m20, matrix.m21,
                                 matrix.m22);
                    end
                end
            end
        end
    end

    task automatic send_word(input angles_t a);
        matrix_t m;
        angle_valid <= 1'b1;
        angles      <= a;
        do
            @(posedge clk);
        while (angle_stall);
        predict_matrix(a, m);
        pending_matrices.push_back(m);
        words_sent++;
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            angle_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_matrices.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return int'($urandom_range(0, 32'd1686629714)) - 843314857;
            2: return int'($urandom_range(0, 32'd8)) + 843314852;
            default: return int'($urandom_range(0, 32'd8)) - 421657432;
        endcase
    endfunction

    task automatic test_directed();
        logic signed [31:0] picks [12];
        picks = '{32'sd0, 32'sd1, -32'sd1, 32'sh7fffffff, 32'sh80000000,
                  32'sd843314856, 32'sd843314857, -32'sd843314857,
                  32'sd421657428, -32'sd421657428, 32'sd1686629713, 32'sd1686629714};
        for (int i = 0; i < 12; i++)
            send_word('{picks[i], picks[(i + 4) % 12], picks[(i + 7) % 12]});
        send_word('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
        send_word('{32'sh80000000, 32'sh80000000, 32'sh80000000});
        send_word('{32'sd421657428, 32'sd421657428, 32'sd421657428});
        send_word('{32'sd843314857, 32'sd0, -32'sd843314857});
    endtask

    task automatic test_backpressure();
        hold_cycles = LONG_HOLD;
        for (int i = 0; i < 100; i++)
            send_word('{rand_angle(), rand_angle(), rand_angle()});
    endtask

    task automatic test_drain_pause();
        angle_valid <= 1'b0;
        wait_drained();
        for (int i = 0; i < 20; i++)
            send_word('{rand_angle(), rand_angle(), rand_angle()});
    endtask

    task automatic test_random();
        for (int i = 0; i < 1150; i++)
            send_word('{rand_angle(), rand_angle(), rand_angle()});
    endtask

    task automatic test_full_rate();
        idling_on = 0;
        for (int i = 0; i < 160; i++)
            send_word('{rand_angle(), rand_angle(), rand_angle()});
        angle_valid <= 1'b0;
    endtask

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        angle_valid   = 1'b0;
        angles        = '0;
        mismatches    = 0;
        words_sent    = 0;
        words_checked = 0;
        idling_on     = 1;
        hold_cycles   = 0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random();
        test_full_rate();
        wait_drained();
        repeat (LATENCY + 5)
            @(posedge clk);
        failed = (mismatches != 0) || (pending_matrices.size() != 0);
        $display("sent %0d angle words, checked %0d matrices, %0d mismatches",
                 words_sent, words_checked, mismatches);
        $display("covered angle extremes, +-pi and +-pi/2 edges, long hold and full rate");
        if (!failed)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/earm_pkg.sv
hdl/euler_angle_rotation_matrix.sv
hdl/earm_checker.sv
dv/tb_top.sv
